/* rtl/hashed_timer_wheel_defines.svh */
// assertion macros for the hashed timer wheel checker
// expects clk_i and rst_ni in the scope of each use
`ifndef HASHED_TIMER_WHEEL_DEFINES_SVH
`define HASHED_TIMER_WHEEL_DEFINES_SVH

// same-cycle implication
`define HTW_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("timer wheel check failed");

// next-cycle implication
`define HTW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("timer wheel check failed");

`endif

/* rtl/htw_pkg.sv */
// shared types and constants of the hashed timer wheel
// no dependencies
package htw_pkg;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned TMO_W     = 32;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned WS_W      = 9;
  localparam int unsigned IV_W      = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DVD_W     = 33;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL = 2'd1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADDED  = 3'd0,
    KIND_FIRED  = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_FULL   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    DIV_TICKS = 2'd0,
    DIV_SLOT  = 2'd1,
    DIV_STEP  = 2'd2
  } div_sel_e;

  typedef enum logic [1:0] {
    ID_NEW  = 2'd0,
    ID_REQ  = 2'd1,
    ID_RAM  = 2'd2,
    ID_ZERO = 2'd3
  } id_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_ZERO_FIRE, ST_ZERO_ADD, ST_FULL,
    ST_ADIV1, ST_ASTART2, ST_ADIV2, ST_AINS,
    ST_CRD, ST_CCMP, ST_CEMIT,
    ST_TDIV, ST_TCNT, ST_TCOMMIT, ST_TRD, ST_TFIRE, ST_TDONE
  } state_e;

  typedef struct packed {
    logic     latch;
    logic     div_start;
    div_sel_e div_sel;
    logic     insert;
    logic     ctr_inc;
    logic     idx_inc;
    logic     cnt_acc;
    logic     tick_commit;
    logic     cancel_clr;
    logic     fire_clr;
    logic     emit;
    kind_e    emit_kind;
    id_sel_e  emit_id;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       tmo_zero;
    logic       rid_zero;
    logic       full;
    logic       div_done;
    logic       idx_last;
    logic       mask_bit;
    logic       hit;
    logic       out_free;
  } status_t;

endpackage

/* rtl/htw_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module htw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/htw_div.sv */
// restoring divider, one quotient bit a cycle
// depends on htw_pkg
module htw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [htw_pkg::DVD_W-1:0] dividend_i,
  input  logic [htw_pkg::IV_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [htw_pkg::DVD_W-1:0] quotient_o,
  output logic [htw_pkg::IV_W-1:0]  remainder_o
);
  import htw_pkg::*;

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [IV_W-1:0]   rem_q, rem_d;
  logic [IV_W-1:0]   dvr_q, dvr_d;
  logic [IV_W:0]     shifted;
  logic [IV_W:0]     trial;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvr_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvr_d  = dvr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit and subtract where it fits
      if (!trial[IV_W]) begin
        rem_d = trial[IV_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[IV_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvr_q <= dvr_d;
  end

  assign done_o      = busy_q && (step_q == STEP_W'(DVD_W - 1));
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/htw_dp.sv */
// datapath: entry table, id store, divider, counters, output register
// depends on htw_pkg, htw_ram, htw_div
module htw_dp #(
  parameter int unsigned MAX_TIMERS = 32,
  parameter int unsigned MAX_SLOTS  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htw_pkg::cmd_t                 cmd_i,
  output htw_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [htw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [htw_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]                    in_op_i,
  input  logic [htw_pkg::TMO_W-1:0]     in_tmo_i,
  input  logic [htw_pkg::ID_W-1:0]      in_id_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [2:0]                    out_kind_o,
  output logic [htw_pkg::ID_W-1:0]      out_id_o,
  output logic                          out_found_o,
  output logic [htw_pkg::SLOT_W-1:0]    out_slot_o,
  output logic [htw_pkg::CNT_W-1:0]     out_cnt_o,
  output logic                          out_last_o
);
  import htw_pkg::*;

  localparam int unsigned IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  // configuration
  logic [WS_W-1:0] ws_q;
  logic [IV_W-1:0] iv_q;
  logic [WS_W-1:0] slots_eff;
  logic [IV_W-1:0] iv_eff;

  // latched item
  logic [1:0]       op_q;
  logic [TMO_W-1:0] tmo_q;
  logic [ID_W-1:0]  rid_q;

  // table and control state
  logic [MAX_TIMERS-1:0] valid_q;
  logic [SLOT_W-1:0]     slot_q [MAX_TIMERS];
  logic [MAX_TIMERS-1:0] mask_q, mask_d;
  logic [IW-1:0]         idx_q;
  logic [IW-1:0]         free_idx;
  logic [CNT_W-1:0]      fired_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SLOT_W-1:0]     sp_q, sp_d;
  logic [ID_W-1:0]       ctr_q;
  logic                  found_q;
  logic [ID_W-1:0]       id_new;
  logic [ID_W-1:0]       ram_rdata;

  // divider
  logic [DVD_W-1:0] div_dvd;
  logic [IV_W-1:0]  div_dvr;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [IV_W-1:0]  div_rem;

  // output register
  logic             ov_q;
  logic [2:0]       okind_q;
  logic [ID_W-1:0]  oid_q;
  logic             ofound_q;
  logic [SLOT_W-1:0] oslot_q;
  logic [CNT_W-1:0] ocnt_q;
  logic             olast_q;
  logic [ID_W-1:0]  emit_id;

  always_comb begin
    if (ws_q == '0) begin
      slots_eff = WS_W'(1);
    end else if (ws_q > WS_W'(MAX_SLOTS)) begin
      slots_eff = WS_W'(MAX_SLOTS);
    end else begin
      slots_eff = ws_q;
    end
  end

  assign iv_eff = (iv_q == '0) ? IV_W'(1) : iv_q;
  assign id_new = ctr_q + 64'd1;

  always_comb begin
    free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      mask_d[i] = valid_q[i] && (slot_q[i] == sp_q);
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_TICKS: begin
        div_dvd = {1'b0, tmo_q} + DVD_W'(iv_eff) - DVD_W'(1);
        div_dvr = iv_eff;
      end
      DIV_SLOT: begin
        div_dvd = DVD_W'(sp_q) + div_quo;
        div_dvr = IV_W'(slots_eff);
      end
      default: begin
        div_dvd = DVD_W'(sp_q) + DVD_W'(1);
        div_dvr = IV_W'(slots_eff);
      end
    endcase
  end

  htw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvr),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  htw_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_TIMERS)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (free_idx),
    .wdata_i (id_new),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    sp_d  = sp_q;
    if (cmd_i.insert) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cancel_clr) begin
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.tick_commit) begin
      cnt_d = cnt_q - fired_q;
      sp_d  = div_rem[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= WS_W'(256);
      iv_q    <= IV_W'(100);
      valid_q <= '0;
      idx_q   <= '0;
      fired_q <= '0;
      cnt_q   <= '0;
      sp_q    <= '0;
      ctr_q   <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WHEEL_SLOTS:   ws_q <= cfg_data_i[WS_W-1:0];
          REG_TICK_INTERVAL: iv_q <= cfg_data_i[IV_W-1:0];
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      sp_q  <= sp_d;
      if (cmd_i.latch) begin
        idx_q   <= '0;
        fired_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.tick_commit) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.cnt_acc && mask_q[idx_q]) begin
        fired_q <= fired_q + 1'b1;
      end
      if (cmd_i.insert) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (cmd_i.cancel_clr || cmd_i.fire_clr) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (cmd_i.cancel_clr) begin
        found_q <= 1'b1;
      end
      if (cmd_i.insert || cmd_i.ctr_inc) begin
        ctr_q <= id_new;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cmd_i.emit_id)
      ID_NEW:  emit_id = id_new;
      ID_REQ:  emit_id = rid_q;
      ID_RAM:  emit_id = ram_rdata;
      default: emit_id = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= in_op_i;
      tmo_q  <= in_tmo_i;
      rid_q  <= in_id_i;
      mask_q <= mask_d;
    end
    if (cmd_i.insert) begin
      slot_q[free_idx] <= div_rem[SLOT_W-1:0];
    end
    if (cmd_i.emit) begin
      okind_q  <= cmd_i.emit_kind;
      oid_q    <= emit_id;
      ofound_q <= found_q;
      oslot_q  <= sp_d;
      ocnt_q   <= cnt_d;
      olast_q  <= cmd_i.emit_last;
    end
  end

  assign status_o.op       = op_q;
  assign status_o.tmo_zero = (tmo_q == '0);
  assign status_o.rid_zero = (rid_q == '0);
  assign status_o.full     = &valid_q;
  assign status_o.div_done = div_done;
  assign status_o.idx_last = (idx_q == IW'(MAX_TIMERS - 1));
  assign status_o.mask_bit = mask_q[idx_q];
  assign status_o.hit      = valid_q[idx_q] && (ram_rdata == rid_q);
  assign status_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_id_o    = oid_q;
  assign out_found_o = ofound_q;
  assign out_slot_o  = oslot_q;
  assign out_cnt_o   = ocnt_q;
  assign out_last_o  = olast_q;

endmodule

/* rtl/htw_ctrl.sv */
// controller state machine sequencing add, cancel and tick
// depends on htw_pkg
module htw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  htw_pkg::status_t status_i,
  output htw_pkg::cmd_t    cmd_o
);
  import htw_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (status_i.op == OP_ADD) begin
          if (status_i.tmo_zero) state_d = ST_ZERO_FIRE;
          else if (status_i.full) state_d = ST_FULL;
          else state_d = ST_ADIV1;
        end else if (status_i.op == OP_CANCEL) begin
          state_d = status_i.rid_zero ? ST_CEMIT : ST_CRD;
        end else if (status_i.op == OP_TICK) begin
          state_d = ST_TDIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ZERO_FIRE: if (status_i.out_free) state_d = ST_ZERO_ADD;
      ST_ZERO_ADD:  if (status_i.out_free) state_d = ST_IDLE;
      ST_FULL:      if (status_i.out_free) state_d = ST_IDLE;
      ST_ADIV1:     if (status_i.div_done) state_d = ST_ASTART2;
      ST_ASTART2:   state_d = ST_ADIV2;
      ST_ADIV2:     if (status_i.div_done) state_d = ST_AINS;
      ST_AINS:      if (status_i.out_free) state_d = ST_IDLE;
      ST_CRD:       state_d = ST_CCMP;
      ST_CCMP: begin
        if (status_i.hit || status_i.idx_last) state_d = ST_CEMIT;
        else state_d = ST_CRD;
      end
      ST_CEMIT:     if (status_i.out_free) state_d = ST_IDLE;
      ST_TDIV:      if (status_i.div_done) state_d = ST_TCNT;
      ST_TCNT:      if (status_i.idx_last) state_d = ST_TCOMMIT;
      ST_TCOMMIT:   state_d = ST_TRD;
      ST_TRD: begin
        if (status_i.mask_bit) state_d = ST_TFIRE;
        else if (status_i.idx_last) state_d = ST_TDONE;
      end
      ST_TFIRE: begin
        if (status_i.out_free) state_d = status_i.idx_last ? ST_TDONE : ST_TRD;
      end
      ST_TDONE:     if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel   = DIV_TICKS;
    cmd_o.emit_kind = KIND_ADDED;
    cmd_o.emit_id   = ID_ZERO;
    case (state_q)
      ST_IDLE: cmd_o.latch = in_valid_i;
      ST_DISPATCH: begin
        if (status_i.op == OP_ADD && !status_i.tmo_zero && !status_i.full) begin
          cmd_o.div_start = 1'b1;
        end else if (status_i.op == OP_TICK) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_STEP;
        end
      end
      ST_ZERO_FIRE: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = KIND_FIRED;
        cmd_o.emit_id   = ID_NEW;
      end
      ST_ZERO_ADD: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.ctr_inc   = status_i.out_free;
        cmd_o.emit_id   = ID_NEW;
        cmd_o.emit_last = 1'b1;
      end
      ST_FULL: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = KIND_FULL;
        cmd_o.emit_last = 1'b1;
      end
      ST_ASTART2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SLOT;
      end
      ST_AINS: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.insert    = status_i.out_free;
        cmd_o.emit_id   = ID_NEW;
        cmd_o.emit_last = 1'b1;
      end
      ST_CCMP: begin
        cmd_o.cancel_clr = status_i.hit;
        cmd_o.idx_inc    = !status_i.hit && !status_i.idx_last;
      end
      ST_CEMIT: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = KIND_CANCEL;
        cmd_o.emit_id   = ID_REQ;
        cmd_o.emit_last = 1'b1;
      end
      ST_TCNT: begin
        cmd_o.cnt_acc = 1'b1;
        cmd_o.idx_inc = !status_i.idx_last;
      end
      ST_TCOMMIT: cmd_o.tick_commit = 1'b1;
      ST_TRD: cmd_o.idx_inc = !status_i.mask_bit && !status_i.idx_last;
      ST_TFIRE: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.fire_clr  = status_i.out_free;
        cmd_o.idx_inc   = status_i.out_free && !status_i.idx_last;
        cmd_o.emit_kind = KIND_FIRED;
        cmd_o.emit_id   = ID_RAM;
      end
      ST_TDONE: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = KIND_TICK;
        cmd_o.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/hashed_timer_wheel.sv */
// top level of the hashed timer wheel: controller plus datapath
// depends on htw_pkg, htw_ctrl, htw_dp
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tuser op, tdata timeout and id
// m_axis    out        m_axis_tvalid/tready      tuser kind, tdata result, tlast
// cfg       in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// one transaction at a time; the sequencer steps from acceptance to the next ready as follows:
// zero-timeout add and add on a full table emit with no divider pass, stored add two 33-step divider passes
// a cancel of a nonzero id walks the id ram, a read then a compare for each entry, until a hit or the last entry
// a tick: a 33-step divider pass for the pointer step, a count pass over all MAX_TIMERS entries,
// then one read per entry and one emit per fired entry
// reset clears the valid bits at once; output stalls hold back the sequencer only
module hashed_timer_wheel #(
  parameter int unsigned MAX_TIMERS = 32,
  parameter int unsigned MAX_SLOTS  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [htw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [htw_pkg::CFG_W-1:0]     cfg_data_i,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // timeout_ms[31:0], timer_id[95:32]
  input  logic [1:0]                    s_axis_tuser,  // operation
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_id[63:0], found[64], current_slot[72:65], task_count[78:73], pad[79]
  output logic [79:0]                   m_axis_tdata,
  output logic [2:0]                    m_axis_tuser,  // kind
  output logic                          m_axis_tlast
);
  import htw_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [ID_W-1:0]   out_id;
  logic              out_found;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_cnt;

  // sequencer, one transaction in flight
  htw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, id ram, divider and output register
  htw_dp #(
    .MAX_TIMERS (MAX_TIMERS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_tmo_i    (s_axis_tdata[31:0]),
    .in_id_i     (s_axis_tdata[95:32]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_id_o    (out_id),
    .out_found_o (out_found),
    .out_slot_o  (out_slot),
    .out_cnt_o   (out_cnt),
    .out_last_o  (m_axis_tlast)
  );

  // pack result fields, highest first
  assign m_axis_tdata = {1'b0, out_cnt, out_slot, out_found, out_id};

endmodule

/* rtl/htw_checker.sv */
// port-level checks on the hashed timer wheel, bound to the top level
// depends on htw_pkg and hashed_timer_wheel_defines.svh
`include "hashed_timer_wheel_defines.svh"

module htw_checker #(
  parameter int unsigned MAX_TIMERS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import htw_pkg::*;

  logic single_kind;

  // kinds that are always the only or final result of a transaction
  assign single_kind = m_axis_tuser inside {KIND_ADDED, KIND_TICK, KIND_CANCEL, KIND_FULL};

  // a stalled result stays offered
  `HTW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // single-result kinds always close their transaction
  `HTW_ASSERT_IMPL(a_single_last, m_axis_tvalid && single_kind, m_axis_tlast)

  // found only on a cancel result
  `HTW_ASSERT_IMPL(a_found_cancel, m_axis_tvalid && m_axis_tdata[64], m_axis_tuser == KIND_CANCEL)

  // pending count never exceeds the table
  `HTW_ASSERT_IMPL(a_count_range, m_axis_tvalid, m_axis_tdata[78:73] <= 6'(MAX_TIMERS))

endmodule

bind hashed_timer_wheel htw_checker #(
  .MAX_TIMERS (MAX_TIMERS)
) u_htw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* bench/testbench.sv */
// self-checking bench for the hashed timer wheel: random and directed commands
// depends on htw_pkg and the hashed_timer_wheel rtl
module testbench;
  import htw_pkg::*;

  localparam int unsigned NTIMERS    = 32;
  localparam int unsigned NSLOTS     = 256;
  // idle cycles tolerated with no transaction on either stream
  localparam int unsigned STALL_LIMIT = 5000;
  // quiet time after the last result before a config write or the end
  localparam int unsigned SETTLE_CYCLES = 200;
  // operation code outside the defined set
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              last;
  } wheel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;    // timeout_ms[31:0], timer_id[95:32]
  logic [1:0] s_axis_tuser = '0;     // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;         // result_id, found, current_slot, task_count, pad
  logic [2:0] m_axis_tuser;          // kind
  logic m_axis_tlast;

  hashed_timer_wheel uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // own copy of the wheel state
  logic              tbl_valid [NTIMERS];
  logic [SLOT_W-1:0] tbl_slot  [NTIMERS];
  logic [ID_W-1:0]   tbl_id    [NTIMERS];
  logic [SLOT_W-1:0] slot_ptr;
  logic [ID_W-1:0]   next_id;
  logic [WS_W-1:0]   wheel_slots;
  logic [IV_W-1:0]   tick_ms;

  wheel_result_t pending_results[$];
  int errors = 0;
  bit idling_on = 1'b1;
  int rx_stall = 0;

  // effective slot count: zero behaves as one, oversize is clamped
  function automatic int unsigned slots_used();
    if (wheel_slots == 0) return 1;
    if (wheel_slots > NSLOTS) return NSLOTS;
    return wheel_slots;
  endfunction

  // work out the results of one accepted command and update the state copy
  task automatic predict_wheel(input logic [1:0] op, input logic [TMO_W-1:0] tmo,
                               input logic [ID_W-1:0] rid);
    wheel_result_t step_q[$];
    wheel_result_t r;
    int free_ix;
    int cnt;
    logic [63:0] iv, nticks, target;
    r = '{KIND_ADDED, '0, 1'b0, '0, '0, 1'b0};
    case (op)
      OP_ADD: begin
        if (tmo == 0) begin
          next_id++;
          r.kind = KIND_FIRED; r.id = next_id; step_q = {step_q, r};
          r.kind = KIND_ADDED; step_q = {step_q, r};
        end else begin
          free_ix = -1;
          for (int i = 0; i < NTIMERS; i++)
            if (!tbl_valid[i] && free_ix < 0) free_ix = i;
          if (free_ix < 0) begin
            r.kind = KIND_FULL; r.id = '0; step_q = {step_q, r};
          end else begin
            iv = (tick_ms == 0) ? 64'd1 : 64'(tick_ms);
            nticks = (64'(tmo) + iv - 1) / iv;
            target = (64'(slot_ptr) + nticks) % 64'(slots_used());
            next_id++;
            tbl_valid[free_ix] = 1'b1;
            tbl_slot[free_ix] = target[SLOT_W-1:0];
            tbl_id[free_ix] = next_id;
            r.kind = KIND_ADDED; r.id = next_id; step_q = {step_q, r};
          end
        end
      end
      OP_CANCEL: begin
        r.kind = KIND_CANCEL; r.id = rid;
        if (rid != 0)
          for (int i = 0; i < NTIMERS; i++)
            if (!r.found && tbl_valid[i] && tbl_id[i] == rid) begin
              tbl_valid[i] = 1'b0;
              r.found = 1'b1;
            end
        step_q = {step_q, r};
      end
      OP_TICK: begin
        // fire in ascending entry order, then step the pointer
        for (int i = 0; i < NTIMERS; i++)
          if (tbl_valid[i] && tbl_slot[i] == slot_ptr) begin
            tbl_valid[i] = 1'b0;
            r.kind = KIND_FIRED; r.id = tbl_id[i]; step_q = {step_q, r};
          end
        slot_ptr = SLOT_W'((32'(slot_ptr) + 1) % slots_used());
        r.kind = KIND_TICK; r.id = '0; step_q = {step_q, r};
      end
      default: ;  // unknown operation: ignored
    endcase
    cnt = 0;
    for (int i = 0; i < NTIMERS; i++) if (tbl_valid[i]) cnt++;
    foreach (step_q[k]) begin
      step_q[k].slot = slot_ptr;
      step_q[k].count = CNT_W'(cnt);
      step_q[k].last = (k == step_q.size() - 1);
      pending_results = {pending_results, step_q[k]};
    end
  endtask

  // send one command; called and returns at a falling edge
  task automatic send_cmd(input logic [1:0] op, input logic [TMO_W-1:0] tmo,
                          input logic [ID_W-1:0] rid);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {rid, tmo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_wheel(op, tmo, rid);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // config writes happen only with the wheel idle
  task automatic write_config(input logic [WS_W-1:0] ws, input logic [IV_W-1:0] iv);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_WHEEL_SLOTS; cfg_data_i <= CFG_W'(ws);
    @(negedge clk_i);
    cfg_idx_i <= REG_TICK_INTERVAL; cfg_data_i <= iv;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    wheel_slots = ws;
    tick_ms = iv;
  endtask

  // id of a random pending timer, or a random id when the table is empty
  function automatic logic [ID_W-1:0] pick_live_id();
    int ix;
    ix = $urandom_range(0, NTIMERS - 1);
    for (int i = 0; i < NTIMERS; i++)
      if (tbl_valid[(ix + i) % NTIMERS]) return tbl_id[(ix + i) % NTIMERS];
    return {$urandom, $urandom};
  endfunction

  // result checker: compare every transaction with the oldest prediction
  always @(posedge clk_i) begin
    wheel_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%h", $time, m_axis_tuser,
                 m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[63:0] !== want.id ||
            m_axis_tdata[64] !== want.found || m_axis_tdata[72:65] !== want.slot ||
            m_axis_tdata[78:73] !== want.count || m_axis_tlast !== want.last) begin
          $display("%0t: mismatch expected kind=%0d id=%h found=%b slot=%0d cnt=%0d last=%b",
                   $time, want.kind, want.id, want.found, want.slot, want.count, want.last);
          $display("%0t:          actual kind=%0d id=%h found=%b slot=%0d cnt=%0d last=%b",
                   $time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[64],
                   m_axis_tdata[72:65], m_axis_tdata[78:73], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      rx_stall <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction at all
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // extremes of every field, each operation and the special cases
  task automatic test_directed();
    logic [ID_W-1:0] live;
    send_cmd(OP_ADD, 32'd0, '0);              // zero timeout fires at once
    send_cmd(OP_ADD, 32'hFFFF_FFFF, '0);      // longest timeout wraps the wheel
    send_cmd(OP_ADD, 32'd1, {ID_W{1'b1}});
    send_cmd(OP_ADD, 32'd100, '0);
    send_cmd(OP_ADD, 32'd101, '0);
    send_cmd(OP_CANCEL, '0, '0);              // id zero is ignored
    send_cmd(OP_CANCEL, '1, {ID_W{1'b1}});    // unknown id
    live = pick_live_id();
    send_cmd(OP_CANCEL, '0, live);
    send_cmd(OP_CANCEL, '0, live);            // already gone
    send_cmd(OP_UNKNOWN, '1, '1);             // unknown operation, no result
    repeat (4) send_cmd(OP_TICK, $urandom, {$urandom, $urandom});
    send_cmd(OP_ADD, 32'h8000_0000, '0);
    send_cmd(OP_TICK, '0, '0);
  endtask

  // fill the table, hit the full case, then drain it by ticks
  task automatic test_table_full();
    write_config(9'd4, 16'd1);
    for (int i = 0; i < NTIMERS + 2; i++) send_cmd(OP_ADD, $urandom_range(1, 40), '0);
    send_cmd(OP_ADD, 32'd0, '0);              // zero timeout still taken when full
    repeat (5) send_cmd(OP_TICK, '0, '0);
  endtask

  // random mix under one setting; mostly live cancels and moderate timeouts
  task automatic test_random(input logic [WS_W-1:0] ws, input logic [IV_W-1:0] iv,
                             input int n);
    int sel;
    logic [TMO_W-1:0] tmo;
    write_config(ws, iv);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        case ($urandom_range(0, 9))
          0: tmo = '0;
          1: tmo = $urandom;
          default: tmo = $urandom_range(1, (slots_used() + 2) * ((iv == 0) ? 1 : iv));
        endcase
        send_cmd(OP_ADD, tmo, {$urandom, $urandom});
      end else if (sel < 62) begin
        send_cmd(OP_CANCEL, $urandom, pick_live_id());
      end else if (sel < 66) begin
        send_cmd(OP_CANCEL, $urandom, ($urandom_range(0, 1) != 0) ? '0 :
                 {$urandom, $urandom});
      end else if (sel < 98) begin
        send_cmd(OP_TICK, $urandom, {$urandom, $urandom});
      end else begin
        send_cmd(OP_UNKNOWN, $urandom, {$urandom, $urandom});
      end
      // let everything drain once mid-phase
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < NTIMERS; i++) tbl_valid[i] = 1'b0;
    slot_ptr = '0;
    next_id = '0;
    wheel_slots = 9'd256;
    tick_ms = 16'd100;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    test_random(9'd256, 16'd100, 70);
    test_random(9'd1, 16'd1, 60);
    test_random(9'd0, 16'd0, 50);
    test_random(9'd511, 16'd65535, 60);
    test_random(9'd7, 16'd3, 70);
    idling_on = 1'b0;                         // no idling in the closing phase
    test_random(9'd16, 16'd50, 80);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/htw_pkg.sv
rtl/htw_ram.sv
rtl/htw_div.sv
rtl/htw_dp.sv
rtl/htw_ctrl.sv
rtl/hashed_timer_wheel.sv
rtl/htw_checker.sv
bench/testbench.sv
